FILE: design/stid_pkg.sv
package stid_pkg;

	// Table depth and derived widths
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int VAL_W    = 32;
	localparam int OUT_CNT_W = 5;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_DELETE  = 2'd1,
		CMD_POP_MIN = 2'd2,
		CMD_POP_MAX = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;
		logic    do_insert;
		logic    do_delete;
		logic    do_pop_min;
		logic    do_pop_max;
		logic    load_result;
		status_t status;
	} dp_ctrl_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic found;
	} dp_stat_t;

	// Keep the low bits of a count for the result word
	function automatic logic [OUT_CNT_W-1:0] to_out_count(input logic [CNT_W-1:0] c);
		logic [CNT_W+OUT_CNT_W-1:0] t;
		t = {{OUT_CNT_W{1'b0}}, c};
		return t[OUT_CNT_W-1:0];
	endfunction

endpackage

FILE: design/stid_req_if.sv
interface stid_req_if;
	import stid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              command;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

FILE: design/stid_rsp_if.sv
interface stid_rsp_if;
	import stid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] removed_value;
	logic [OUT_CNT_W-1:0]    entry_count;

	modport source (output valid, output status, output removed_value, output entry_count,
		input ready);
	modport sink   (input valid, input status, input removed_value, input entry_count,
		output ready);
endinterface

FILE: design/sorted_table_insert_delete_top.sv
// Sorted table of up to CAPACITY signed 32-bit values kept in ascending order in a row of
// cells. Each command word (insert, delete by key, pop smallest, pop largest) gives exactly
// one result word with a status, the removed value and the new entry count. A command
// passes through the states ST_IDLE, in which the word is taken, and ST_EXEC, in which
// every cell compares with the operand and the row shifts; the next command word can be
// accepted only back in ST_IDLE, once the last one is done. A result waiting in the output
// register blocks the next command until it is taken; it may be taken in the same cycle in
// which the next command is accepted. No clearing pass runs after reset; cells above the
// count are never read.
module sorted_table_insert_delete_top (
	input logic        clk,
	input logic        arst_n,
	stid_req_if.sink   req,
	stid_rsp_if.source rsp
);
	import stid_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	stid_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.stat        (stat),
		.ctrl        (ctrl)
	);

	stid_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.value         (req.value),
		.stat          (stat),
		.status        (rsp.status),
		.removed_value (rsp.removed_value),
		.entry_count   (rsp.entry_count)
	);

endmodule

FILE: design/stid_ctrl.sv
module stid_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [1:0]         req_command,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  stid_pkg::dp_stat_t stat,
	output stid_pkg::dp_ctrl_t ctrl
);
	import stid_pkg::*;

	ctrl_state_t state_q, state_nxt;
	cmd_t        cmd_q;
	logic        out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the command of the word in flight
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= cmd_t'(req_command);
		end
	end

	// Result word valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_result) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		req_ready = 1'b0;
		ctrl      = '0;
		ctrl.status = STAT_OK;
		case (state_q)
			ST_IDLE: begin
				req_ready    = !out_valid_q || rsp_ready;
				ctrl.capture = req_valid && req_ready;
				if (ctrl.capture) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.load_result = 1'b1;
				state_nxt        = ST_IDLE;
				if (cmd_q == CMD_INSERT) begin
					if (stat.full) begin
						ctrl.status = STAT_FULL;
					end else begin
						ctrl.do_insert = 1'b1;
					end
				end else if (stat.empty) begin
					ctrl.status = STAT_EMPTY;
				end else begin
					case (cmd_q)
						CMD_DELETE: begin
							if (stat.found) begin
								ctrl.do_delete = 1'b1;
							end else begin
								ctrl.status = STAT_NOTFOUND;
							end
						end
						CMD_POP_MIN: ctrl.do_pop_min = 1'b1;
						CMD_POP_MAX: ctrl.do_pop_max = 1'b1;
						default:     ctrl.status = STAT_OK;
					endcase
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/stid_dp.sv
module stid_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stid_pkg::dp_ctrl_t                ctrl,
	input  logic signed [stid_pkg::VAL_W-1:0] value,
	output stid_pkg::dp_stat_t                stat,
	output logic [1:0]                        status,
	output logic signed [stid_pkg::VAL_W-1:0] removed_value,
	output logic [stid_pkg::OUT_CNT_W-1:0]    entry_count
);
	import stid_pkg::*;

	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] entry_q    [CAPACITY];
	logic signed [VAL_W-1:0] up_entry   [CAPACITY];
	logic signed [VAL_W-1:0] prev_entry [CAPACITY];
	logic [CAPACITY-1:0]     gt, ge, eq, prev_gt;
	logic [CNT_W-1:0]        count_q, count_nxt, last_pos;
	logic signed [VAL_W-1:0] removed_nxt;

	// Hold the operand of the word in flight
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			value_q <= value;
		end
	end

	// Cell array: each cell compares with the operand and shifts with its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] POS = CNT_W'(i);
		logic live;

		assign live  = POS < count_q;
		assign gt[i] = live && (entry_q[i] > value_q);
		assign ge[i] = live && (entry_q[i] >= value_q);
		assign eq[i] = live && (entry_q[i] == value_q);

		if (i > 0) begin : g_prev
			assign prev_entry[i] = entry_q[i-1];
			assign prev_gt[i]    = gt[i-1];
		end else begin : g_first
			assign prev_entry[i] = value_q;
			assign prev_gt[i]    = 1'b0;
		end

		if (i + 1 < CAPACITY) begin : g_up
			assign up_entry[i] = entry_q[i+1];
		end else begin : g_last
			assign up_entry[i] = entry_q[i];
		end

		always_ff @(posedge clk) begin
			if (ctrl.do_insert) begin
				if (prev_gt[i]) begin
					entry_q[i] <= prev_entry[i];
				end else if (gt[i] || POS == count_q) begin
					entry_q[i] <= value_q;
				end
			end else if ((ctrl.do_delete && ge[i]) || ctrl.do_pop_min) begin
				entry_q[i] <= up_entry[i];
			end
		end
	end

	// Flags for the controller
	assign stat.full  = count_q == CNT_W'(CAPACITY);
	assign stat.empty = count_q == '0;
	assign stat.found = |eq;

	assign last_pos = count_q - CNT_W'(1);

	// Count and removed value after this command
	always_comb begin
		count_nxt   = count_q;
		removed_nxt = '0;
		if (ctrl.do_insert) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.do_delete || ctrl.do_pop_min || ctrl.do_pop_max) begin
			count_nxt = count_q - CNT_W'(1);
		end
		if (ctrl.do_delete) begin
			removed_nxt = value_q;
		end else if (ctrl.do_pop_min) begin
			removed_nxt = entry_q[0];
		end else if (ctrl.do_pop_max) begin
			removed_nxt = entry_q[last_pos[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctrl.load_result) begin
			status        <= ctrl.status;
			removed_value <= removed_nxt;
			entry_count   <= to_out_count(count_nxt);
		end
	end

endmodule

FILE: design/stid_checker.sv
module stid_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [1:0]                        rsp_status,
	input logic signed [stid_pkg::VAL_W-1:0] rsp_removed_value,
	input logic [stid_pkg::OUT_CNT_W-1:0]    rsp_entry_count
);
	import stid_pkg::*;

	// A stalled result word stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	// One command in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command accepted while another is in flight");

	// An empty table reports no entries and nothing removed
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_EMPTY |->
			rsp_entry_count == '0 && rsp_removed_value == '0)
		else $error("empty status with entries or removed value");

	// A refused insert reports a full table and nothing removed
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_FULL |->
			rsp_entry_count == to_out_count(CNT_W'(CAPACITY)) && rsp_removed_value == '0)
		else $error("full status with wrong count or removed value");

endmodule

bind sorted_table_insert_delete_top stid_checker u_stid_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_removed_value (rsp.removed_value),
	.rsp_entry_count   (rsp.entry_count)
);

FILE: tb/sorted_table_checker.sv
module sorted_table_checker (
	input  logic clk,
	input  logic arst_n,
	stid_req_if  req,
	stid_rsp_if  rsp,
	output int   fail_count,
	output int   outstanding
);
	import stid_pkg::*;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] removed_value;
		logic [OUT_CNT_W-1:0]    entry_count;
	} table_result_t;

	// Predicted table contents, ascending; only rows below row_count are valid
	logic signed [VAL_W-1:0] table_rows [CAPACITY];
	int unsigned             row_count;
	table_result_t           expected_results [$];
	table_result_t           want;
	int                      word_errors;

	// Close the gap at pos by moving the upper rows down one place
	function automatic void close_gap(input int unsigned pos);
		int unsigned i;
		for (i = pos; i + 1 < row_count; i++)
			table_rows[i] = table_rows[i + 1];
		row_count--;
	endfunction

	// Apply one command to the predicted table and return the result word it gives
	function automatic table_result_t apply_command(input cmd_t cmd,
		input logic signed [VAL_W-1:0] operand);
		table_result_t r;
		int unsigned   pos;
		int unsigned   i;
		bit            hit;
		r.status        = STAT_OK;
		r.removed_value = '0;
		hit             = 1'b0;
		if (cmd == CMD_INSERT) begin
			if (row_count >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				pos = row_count;
				while (pos > 0 && table_rows[pos - 1] > operand) begin
					table_rows[pos] = table_rows[pos - 1];
					pos--;
				end
				table_rows[pos] = operand;
				row_count++;
			end
		end else if (row_count == 0) begin
			r.status = STAT_EMPTY;
		end else if (cmd == CMD_DELETE) begin
			pos = 0;
			for (i = 0; i < row_count; i++) begin
				if (!hit && table_rows[i] == operand) begin
					hit = 1'b1;
					pos = i;
				end
			end
			if (hit) begin
				r.removed_value = table_rows[pos];
				close_gap(pos);
			end else begin
				r.status = STAT_NOTFOUND;
			end
		end else if (cmd == CMD_POP_MIN) begin
			r.removed_value = table_rows[0];
			close_gap(0);
		end else begin
			r.removed_value = table_rows[row_count - 1];
			row_count--;
		end
		r.entry_count = OUT_CNT_W'(row_count);
		return r;
	endfunction

	// Check each result word against the oldest prediction, then predict for new commands
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count = 0;
			expected_results.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			word_errors = 0;
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no command waiting");
					word_errors++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						word_errors++;
					end
					if (rsp.removed_value !== want.removed_value) begin
						$error("removed_value: expected %0d, actual %0d",
							want.removed_value, rsp.removed_value);
						word_errors++;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
							want.entry_count, rsp.entry_count);
						word_errors++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(apply_command(cmd_t'(req.command), req.value));
			outstanding <= expected_results.size();
			fail_count  <= fail_count + word_errors;
		end
	end

endmodule

FILE: tb/testbench.sv
module testbench;
	import stid_pkg::*;

	localparam int RANDOM_WORDS    = 600;
	localparam int STALL_LIMIT     = 1000;
	localparam int HOLD_OFF_START  = 200;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int DRAIN_CYCLES    = 8;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   stall_cycles;
	bit   send_quiet;

	logic signed [VAL_W-1:0] key_pool [8];

	stid_req_if req_ch ();
	stid_rsp_if rsp_ch ();

	sorted_table_insert_delete_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	sorted_table_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Offer one command word, with random idle cycles ahead of it, and hold it until taken
	task automatic send_command(input cmd_t cmd, input logic signed [VAL_W-1:0] operand);
		while (!send_quiet && $urandom_range(99) < 8) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.value   <= operand;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Mostly reuse a few keys so deletes hit, sometimes a fully random word
	function automatic logic signed [VAL_W-1:0] pick_operand();
		if ($urandom_range(99) < 20)
			return $urandom;
		return key_pool[$urandom_range(7)];
	endfunction

	// Pick a command; fill phases lean toward inserts, drain phases toward removals
	function automatic cmd_t pick_command(input bit fill_phase);
		int r;
		r = $urandom_range(99);
		if (r < (fill_phase ? 70 : 25))
			return CMD_INSERT;
		r = $urandom_range(3);
		if (r < 2)
			return CMD_DELETE;
		return (r == 2) ? CMD_POP_MIN : CMD_POP_MAX;
	endfunction

	// Receiver: random stalls, a quiet window and one long hold-off
	initial begin : result_sink
		int cycle;
		rsp_ch.ready <= 1'b0;
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle == HOLD_OFF_START) begin
				repeat (HOLD_OFF_CYCLES) begin
					rsp_ch.ready <= 1'b0;
					@(posedge clk);
					cycle++;
				end
			end
			if (cycle >= 400 && cycle < 700)
				rsp_ch.ready <= 1'b1;
			else
				rsp_ch.ready <= ($urandom_range(99) >= 8);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("sorted_table_insert_delete_top test failed");
			$finish;
		end
	end

	initial begin : command_source
		int k;
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.command <= CMD_INSERT;
		req_ch.value   <= '0;
		send_quiet     = 1'b0;
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 0;
		key_pool[3] = -1;
		for (k = 4; k < 8; k++)
			key_pool[k] = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Removals on an empty table
		send_command(CMD_POP_MIN, 0);
		send_command(CMD_POP_MAX, 0);
		send_command(CMD_DELETE, 5);
		// Pop on a one-entry table
		send_command(CMD_INSERT, 0);
		send_command(CMD_POP_MAX, 0);
		// Extremes and duplicates
		send_command(CMD_INSERT, 32'sh7fff_ffff);
		send_command(CMD_INSERT, 32'sh8000_0000);
		send_command(CMD_INSERT, -1);
		send_command(CMD_INSERT, -1);
		send_command(CMD_INSERT, 0);
		// Missing key, then hits
		send_command(CMD_DELETE, 12345);
		send_command(CMD_DELETE, -1);
		send_command(CMD_POP_MIN, 0);
		send_command(CMD_POP_MAX, 0);
		// Fill to capacity, then try one more
		for (k = 0; k < CAPACITY - 2; k++)
			send_command(CMD_INSERT, 1000 - k * 7);
		send_command(CMD_INSERT, 5);
		send_command(CMD_DELETE, 0);

		// Random part: alternate fill and drain phases
		for (k = 0; k < RANDOM_WORDS; k++) begin
			send_quiet = (k >= 200 && k < 300);
			if (k == 450) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0)
					@(posedge clk);
			end
			send_command(pick_command(((k / 40) % 2) == 0), pick_operand());
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding results, then watch for stray words
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sorted_table_insert_delete_top test passed");
		else
			$display("sorted_table_insert_delete_top test failed");
		$finish;
	end

endmodule

FILE: sim.f
design/stid_pkg.sv
design/stid_req_if.sv
design/stid_rsp_if.sv
design/stid_ctrl.sv
design/stid_dp.sv
design/sorted_table_insert_delete_top.sv
design/stid_checker.sv
tb/sorted_table_checker.sv
tb/testbench.sv
